[rtl/bttr_pkg.sv]
// ----------------------------------------------------------------------------
// Bitmap text row renderer package
// Shared beat types, field widths, opcodes and register indexes.
// ----------------------------------------------------------------------------
package bttr_pkg;

    localparam int COORD_W = 11;
    localparam int MASK_W  = 20;
    localparam int WORD_W  = 24;
    localparam int COLOR_W = 24;
    localparam int CFG_IDX_W = 8;

    localparam int GLYPH_COUNT = 96;

    localparam logic [1:0] OP_LOAD_FONT  = 2'd0;
    localparam logic [1:0] OP_RENDER     = 2'd1;
    localparam logic [1:0] OP_START_TEXT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 8'd3;

    localparam logic [COORD_W-1:0] SCREEN_WIDTH_RST  = 11'd800;
    localparam logic [COORD_W-1:0] SCREEN_HEIGHT_RST = 11'd480;

    localparam logic [7:0] FIRST_CODE      = 8'h20;
    localparam logic [7:0] CODE_LIMIT      = 8'h80;
    localparam logic [7:0] NEWLINE_CODE    = 8'h0A;
    localparam logic [7:0] LAST_START_LINE = 8'd19;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [7:0]        char_code;
        logic [4:0]        glyph_row;
        logic [WORD_W-1:0] row_word;
        logic [7:0]        start_line;
    } t_in_item;

    typedef struct packed {
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [MASK_W-1:0]  pixel_mask;
        logic               last_row;
    } t_out_item;

endpackage

[rtl/bttr_font_mem.sv]
// ----------------------------------------------------------------------------
// Font memory
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module bttr_font_mem
    import bttr_pkg::*;
#(
    parameter int DEPTH  = 2304,
    parameter int ADDR_W = 12
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WORD_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WORD_W-1:0] o_rd_data
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/bttr_step_alu.sv]
// ----------------------------------------------------------------------------
// Cursor step adder
// Adds a step to a coordinate and compares the sum against a screen limit.
// ----------------------------------------------------------------------------
module bttr_step_alu
    import bttr_pkg::*;
#(
    parameter int VAL_W = 12,
    parameter int ADD_W = 7
) (
    input  logic [VAL_W-1:0]   i_base,
    input  logic [ADD_W-1:0]   i_step,
    input  logic [COORD_W-1:0] i_limit,
    output logic [VAL_W-1:0]   o_sum,
    output logic               o_over
);

    logic [VAL_W:0] sum_w;

    assign sum_w  = {1'b0, i_base} + (VAL_W+1)'(i_step);
    assign o_sum  = sum_w[VAL_W-1:0];
    assign o_over = sum_w > (VAL_W+1)'(i_limit);

endmodule

[rtl/bitmap_text_row_renderer.sv]
// ----------------------------------------------------------------------------
// Bitmap text row renderer
// Font loads and text starts are taken while idle and do not stall the input. A
// printable character emits one glyph row per cycle from the single font memory
// read port while the output does not stall, then takes three or four cursor
// steps through the shared step adder. A newline takes only the cursor steps.
// Reset is synchronous: cursor at the origin, not halted, font memory undefined.
// ----------------------------------------------------------------------------
module bitmap_text_row_renderer
    import bttr_pkg::*;
#(
    parameter int ROW_PIXELS  = 20,
    parameter int PAD_BITS    = 4,
    parameter int GLYPH_ROWS  = 24,
    parameter int CELL_WIDTH  = 20,
    parameter int CELL_HEIGHT = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COLOR_W-1:0]   i_cfg_data
);

    localparam int DEPTH    = GLYPH_COUNT * GLYPH_ROWS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int ROW_W    = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
    localparam int STEP_A   = (CELL_WIDTH > CELL_HEIGHT) ? CELL_WIDTH : CELL_HEIGHT;
    localparam int STEP_MAX = (STEP_A > GLYPH_ROWS) ? STEP_A : GLYPH_ROWS;
    localparam int ADD_W    = $clog2(STEP_MAX + 1);
    localparam int CUR_W    = $clog2(2048 + 3 * STEP_MAX);
    localparam logic [ROW_W-1:0]  LAST_ROW_IDX = ROW_W'(GLYPH_ROWS - 1);
    localparam logic [ADD_W-1:0]  CW_STEP      = ADD_W'(CELL_WIDTH);
    localparam logic [ADD_W-1:0]  CH_STEP      = ADD_W'(CELL_HEIGHT);
    localparam logic [WORD_W-1:0] PIX_ONES     = WORD_W'((1 << ROW_PIXELS) - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMIT,
        S_DRAIN,
        S_ADV,
        S_WRAP_CHK,
        S_WRAP_Y,
        S_BOTTOM
    } t_state;

    t_state             r_state;
    logic [CUR_W-1:0]   r_x;
    logic [CUR_W-1:0]   r_y;
    logic               r_halted;
    logic               r_nl;
    logic [ADDR_W-1:0]  r_base;
    logic [ROW_W-1:0]   r_row;
    logic               r_pend;
    logic [ROW_W-1:0]   r_pend_row;
    logic               r_pend_last;
    logic               r_out_valid;
    t_out_item          r_out_data;
    logic [COORD_W-1:0] r_screen_width;
    logic [COORD_W-1:0] r_screen_height;

    logic               in_accept;
    logic               printable;
    logic [6:0]         code_off;
    logic [ADDR_W-1:0]  code_base;
    logic               load_wr;
    logic               out_free;
    logic               load_out;
    logic               issue;
    logic [WORD_W-1:0]  rd_data;
    logic [WORD_W-1:0]  mask_full;
    logic [CUR_W-1:0]   alu_base;
    logic [ADD_W-1:0]   alu_step;
    logic [COORD_W-1:0] alu_limit;
    logic [CUR_W-1:0]   alu_sum;
    logic               alu_over;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign in_accept = i_in_valid && !o_in_stall;
    assign printable = (i_in_data.char_code >= FIRST_CODE)
                    && (i_in_data.char_code < CODE_LIMIT);
    assign code_off  = 7'(i_in_data.char_code - FIRST_CODE);
    assign code_base = ADDR_W'(int'(code_off) * GLYPH_ROWS);
    assign load_wr   = in_accept && (i_in_data.opcode == OP_LOAD_FONT) && printable
                    && ({1'b0, i_in_data.glyph_row} < 6'(GLYPH_ROWS));

    assign out_free  = !r_out_valid || !i_out_stall;
    assign load_out  = r_pend && out_free;
    assign issue     = (r_state == S_EMIT) && (!r_pend || load_out);
    assign mask_full = (rd_data >> PAD_BITS) & PIX_ONES;

    bttr_font_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_font_mem (
        .i_clk     (i_clk),
        .i_wr_en   (load_wr),
        .i_wr_addr (code_base + ADDR_W'(i_in_data.glyph_row)),
        .i_wr_data (i_in_data.row_word),
        .i_rd_en   (issue),
        .i_rd_addr (r_base + ADDR_W'(r_row)),
        .o_rd_data (rd_data)
    );

    always_comb begin
        alu_base  = r_y;
        alu_step  = ADD_W'(r_pend_row);
        alu_limit = r_screen_height;
        case (r_state)
            S_ADV: begin
                alu_base = r_nl ? r_y : r_x;
                alu_step = r_nl ? CH_STEP : CW_STEP;
            end
            S_WRAP_CHK: begin
                alu_base  = r_x;
                alu_step  = CW_STEP;
                alu_limit = r_screen_width;
            end
            S_WRAP_Y, S_BOTTOM: begin
                alu_step = CH_STEP;
            end
            default: begin
            end
        endcase
    end

    bttr_step_alu #(
        .VAL_W (CUR_W),
        .ADD_W (ADD_W)
    ) u_step_alu (
        .i_base  (alu_base),
        .i_step  (alu_step),
        .i_limit (alu_limit),
        .o_sum   (alu_sum),
        .o_over  (alu_over)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_x             <= '0;
            r_y             <= '0;
            r_halted        <= 1'b0;
            r_nl            <= 1'b0;
            r_row           <= '0;
            r_pend          <= 1'b0;
            r_out_valid     <= 1'b0;
            r_screen_width  <= SCREEN_WIDTH_RST;
            r_screen_height <= SCREEN_HEIGHT_RST;
        end else begin
            // Color writes are accepted and need no storage here.
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data[COORD_W-1:0];
                    CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data[COORD_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (load_out) begin
                r_out_valid           <= 1'b1;
                r_out_data.pos_x      <= r_x[COORD_W-1:0];
                r_out_data.pos_y      <= alu_sum[COORD_W-1:0];
                r_out_data.pixel_mask <= mask_full[MASK_W-1:0];
                r_out_data.last_row   <= r_pend_last;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (issue) begin
                r_pend      <= 1'b1;
                r_pend_row  <= r_row;
                r_pend_last <= (r_row == LAST_ROW_IDX);
            end else if (load_out) begin
                r_pend <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept && (i_in_data.opcode == OP_START_TEXT)) begin
                        if (i_in_data.start_line > LAST_START_LINE) begin
                            r_halted <= 1'b1;
                        end else begin
                            r_x      <= '0;
                            r_y      <= CUR_W'(int'(i_in_data.start_line[4:0]) * CELL_HEIGHT);
                            r_halted <= 1'b0;
                        end
                    end else if (in_accept && (i_in_data.opcode == OP_RENDER)
                                 && !r_halted) begin
                        if (i_in_data.char_code == NEWLINE_CODE) begin
                            r_nl    <= 1'b1;
                            r_state <= S_ADV;
                        end else if (printable) begin
                            r_nl    <= 1'b0;
                            r_base  <= code_base;
                            r_row   <= '0;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (issue) begin
                        r_row <= r_row + 1'b1;
                        if (r_row == LAST_ROW_IDX) begin
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: begin
                    if (load_out) begin
                        r_state <= S_ADV;
                    end
                end
                S_ADV: begin
                    if (r_nl) begin
                        r_x <= '0;
                        r_y <= alu_sum;
                    end else begin
                        r_x <= alu_sum;
                    end
                    r_state <= S_WRAP_CHK;
                end
                S_WRAP_CHK: begin
                    r_state <= alu_over ? S_WRAP_Y : S_BOTTOM;
                end
                S_WRAP_Y: begin
                    r_x     <= '0;
                    r_y     <= alu_sum;
                    r_state <= S_BOTTOM;
                end
                S_BOTTOM: begin
                    if (alu_over) begin
                        r_halted <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_emit_not_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !r_halted)
        else $error("Glyph rows are being emitted while halted.");

    a_pend_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && !load_out) |=> (r_pend && $stable(r_pend_row)))
        else $error("A fetched glyph row was dropped before reaching the output.");

    a_last_then_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && r_pend_last) |=> (r_state == S_ADV))
        else $error("The final glyph row did not lead to a cursor advance.");

    a_cursor_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) || (r_state == S_DRAIN)) |=> $stable(r_x))
        else $error("The cursor moved while glyph rows were in flight.");

endmodule

[tb/bitmap_text_row_renderer_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bitmap text row renderer testbench
// Loads a font, sends text and control beats with random gaps on both
// channels, predicts every glyph row beat from a cursor and font model of its
// own, and checks each output beat field by field under several screen sizes.
// ----------------------------------------------------------------------------
module bitmap_text_row_renderer_test;
    import bttr_pkg::*;

    localparam int ROW_PIXELS  = 20;
    localparam int PAD_BITS    = 4;
    localparam int GLYPH_ROWS  = 24;
    localparam int CELL_WIDTH  = 20;
    localparam int CELL_HEIGHT = 24;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int STORE_DEPTH  = GLYPH_COUNT * GLYPH_ROWS;
    localparam int DRAIN_CYCLES = GLYPH_ROWS + 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_item             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [COLOR_W-1:0]   i_cfg_data;

    // Model of the renderer state.
    int unsigned      cur_x;
    int unsigned      cur_y;
    bit               text_stopped;
    int unsigned      scr_width;
    int unsigned      scr_height;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
    logic [WORD_W-1:0] font_mem [STORE_DEPTH];
    bit               glyph_loaded [GLYPH_COUNT];
    logic [7:0]       loaded_codes [$];

    t_out_item        pending_rows [$];

    int idle_pct = 36;
    int hold_asked;
    int hold_served;
    int cycle_count;
    int failures;
    int beats_sent;
    int rows_checked;
    int settings_used;

    bitmap_text_row_renderer #(
        .ROW_PIXELS (ROW_PIXELS),
        .PAD_BITS   (PAD_BITS),
        .GLYPH_ROWS (GLYPH_ROWS),
        .CELL_WIDTH (CELL_WIDTH),
        .CELL_HEIGHT(CELL_HEIGHT)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("bitmap_text_row_renderer_test: FAIL");
            $finish;
        end
    end

    // Output stall: random, or held high for a long stretch on request.
    always @(negedge i_clk) begin : out_stall_drive
        int hold_left;
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall = 1'b1;
        end else if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall = 1'b1;
        end else begin
            i_out_stall = ($urandom_range(99) < idle_pct);
        end
    end

    always @(posedge i_clk) begin : row_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_rows.size() == 0) begin
                $error("unexpected output beat: x %0d y %0d mask %h", o_out_data.pos_x,
                       o_out_data.pos_y, o_out_data.pixel_mask);
                failures++;
            end else begin
                want = pending_rows.pop_front();
                rows_checked++;
                if (o_out_data.pos_x !== want.pos_x) begin
                    $error("pos_x: expected %0d, got %0d", want.pos_x, o_out_data.pos_x);
                    failures++;
                end
                if (o_out_data.pos_y !== want.pos_y) begin
                    $error("pos_y: expected %0d, got %0d", want.pos_y, o_out_data.pos_y);
                    failures++;
                end
                if (o_out_data.pixel_mask !== want.pixel_mask) begin
                    $error("pixel_mask: expected %h, got %h", want.pixel_mask,
                           o_out_data.pixel_mask);
                    failures++;
                end
                if (o_out_data.last_row !== want.last_row) begin
                    $error("last_row: expected %0d, got %0d", want.last_row,
                           o_out_data.last_row);
                    failures++;
                end
            end
        end
    end

    task automatic check_screen_edges();
        if (cur_x + CELL_WIDTH > scr_width) begin
            cur_y += CELL_HEIGHT;
            cur_x = 0;
        end
        if (cur_y + CELL_HEIGHT > scr_height) begin
            text_stopped = 1'b1;
        end
    endtask

    task automatic predict_glyph_rows(input t_in_item it);
        int base;
        int slot;
        t_out_item row;
        case (it.opcode)
            OP_LOAD_FONT: begin
                if (it.char_code >= FIRST_CODE && it.char_code < CODE_LIMIT
                        && it.glyph_row < GLYPH_ROWS) begin
                    slot = (int'(it.char_code) - int'(FIRST_CODE)) * GLYPH_ROWS
                           + int'(it.glyph_row);
                    font_mem[slot] = it.row_word;
                end
            end
            OP_START_TEXT: begin
                if (it.start_line > LAST_START_LINE) begin
                    text_stopped = 1'b1;
                end else begin
                    cur_x = 0;
                    cur_y = int'(it.start_line) * CELL_HEIGHT;
                    text_stopped = 1'b0;
                end
            end
            OP_RENDER: begin
                if (!text_stopped) begin
                    if (it.char_code == NEWLINE_CODE) begin
                        cur_y += CELL_HEIGHT;
                        cur_x = 0;
                        check_screen_edges();
                    end else if (it.char_code >= FIRST_CODE && it.char_code < CODE_LIMIT) begin
                        base = (int'(it.char_code) - int'(FIRST_CODE)) * GLYPH_ROWS;
                        for (int r = 0; r < GLYPH_ROWS; r++) begin
                            row.pos_x = COORD_W'(cur_x);
                            row.pos_y = COORD_W'(cur_y + r);
                            row.pixel_mask = MASK_W'(font_mem[base + r] >> PAD_BITS);
                            row.last_row = (r == GLYPH_ROWS - 1);
                            pending_rows.push_back(row);
                        end
                        cur_x += CELL_WIDTH;
                        check_screen_edges();
                    end
                end
            end
            default: ;
        endcase
    endtask

    function automatic t_in_item random_item();
        t_in_item it;
        it.opcode = 2'($urandom_range(3));
        it.char_code = 8'($urandom_range(255));
        it.glyph_row = 5'($urandom_range(31));
        it.row_word = WORD_W'($urandom);
        it.start_line = 8'($urandom_range(255));
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data = it;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        predict_glyph_rows(it);
        beats_sent++;
    endtask

    task automatic send_char(input logic [7:0] code);
        t_in_item it;
        it = random_item();
        it.opcode = OP_RENDER;
        it.char_code = code;
        send_item(it);
    endtask

    task automatic send_start(input logic [7:0] line);
        t_in_item it;
        it = random_item();
        it.opcode = OP_START_TEXT;
        it.start_line = line;
        send_item(it);
    endtask

    task automatic send_load(input logic [7:0] code, input logic [4:0] row,
                             input logic [WORD_W-1:0] word);
        t_in_item it;
        it = random_item();
        it.opcode = OP_LOAD_FONT;
        it.char_code = code;
        it.glyph_row = row;
        it.row_word = word;
        send_item(it);
    endtask

    task automatic load_glyph(input logic [7:0] code, input bit fixed,
                              input logic [WORD_W-1:0] word);
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            send_load(code, 5'(r), fixed ? word : WORD_W'($urandom));
        end
        if (!glyph_loaded[code - FIRST_CODE]) begin
            glyph_loaded[code - FIRST_CODE] = 1'b1;
            loaded_codes.push_back(code);
        end
    endtask

    function automatic logic [7:0] any_loaded_code();
        return loaded_codes[$urandom_range(loaded_codes.size() - 1)];
    endfunction

    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_rows.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [COLOR_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data = value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (index)
            CFG_FG_COLOR:      fg_color = value;
            CFG_BG_COLOR:      bg_color = value;
            CFG_SCREEN_WIDTH:  scr_width = value[COORD_W-1:0];
            CFG_SCREEN_HEIGHT: scr_height = value[COORD_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_screen(input int unsigned width, input int unsigned height,
                              input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
        settle();
        write_reg(CFG_FG_COLOR, fg);
        write_reg(CFG_BG_COLOR, bg);
        write_reg(CFG_SCREEN_WIDTH, COLOR_W'(width));
        write_reg(CFG_SCREEN_HEIGHT, COLOR_W'(height));
        settings_used++;
    endtask

    task automatic test_font_setup();
        load_glyph(FIRST_CODE, 1'b1, '0);
        load_glyph(8'h7F, 1'b1, '1);
        load_glyph(8'h41, 1'b0, '0);
        load_glyph(8'h55, 1'b0, '0);
        load_glyph(8'h2A, 1'b0, '0);
        load_glyph(8'h6B, 1'b0, '0);
    endtask

    task automatic test_special_codes();
        t_in_item it;
        send_char(8'h7F);
        send_char(FIRST_CODE);
        send_char(NEWLINE_CODE);
        send_char(8'h00);
        send_char(FIRST_CODE - 8'd1);
        send_char(CODE_LIMIT);
        send_char(8'hFF);
        it = random_item();
        it.opcode = OP_UNUSED;
        send_item(it);
        send_load(FIRST_CODE - 8'd1, 5'd0, WORD_W'($urandom));
        send_load(CODE_LIMIT, 5'd0, WORD_W'($urandom));
        send_load(8'h41, 5'(GLYPH_ROWS), WORD_W'($urandom));
        send_load(8'h41, 5'd31, WORD_W'($urandom));
        send_char(8'h41);
        send_start(LAST_START_LINE);
        send_char(8'h7F);
        send_start(LAST_START_LINE + 8'd1);
        send_char(8'h41);
        send_char(NEWLINE_CODE);
        send_start(8'hFF);
        send_start(8'd0);
        send_char(8'h41);
    endtask

    task automatic test_wrap_and_bottom();
        set_screen(3 * CELL_WIDTH, 3 * CELL_HEIGHT, 24'h123456, 24'h654321);
        send_start(8'd0);
        for (int i = 0; i < 8; i++) begin
            send_char(any_loaded_code());
        end
        send_char(8'h55);
        send_start(8'd1);
        send_char(8'h2A);
        send_char(NEWLINE_CODE);
        send_char(NEWLINE_CODE);
        send_char(8'h6B);
    endtask

    task automatic test_screen_extremes();
        set_screen(1, 1, '0, '1);
        send_start(8'd0);
        send_char(8'h7F);
        send_char(8'h41);
        send_start(8'd5);
        send_char(8'h55);
        set_screen(2047, 2047, '1, '0);
        send_start(LAST_START_LINE);
        for (int i = 0; i < 6; i++) begin
            send_char(any_loaded_code());
        end
        send_char(NEWLINE_CODE);
        send_char(8'h2A);
    endtask

    task automatic test_output_hold();
        set_screen(SCREEN_WIDTH_RST, SCREEN_HEIGHT_RST, '1, '0);
        send_start(8'd0);
        hold_asked++;
        for (int i = 0; i < 10; i++) begin
            send_char(any_loaded_code());
        end
    endtask

    task automatic random_traffic(input int count);
        int sel;
        logic [7:0] code;
        t_in_item it;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(99);
            if (text_stopped && sel < 50) begin
                send_start(8'($urandom_range(LAST_START_LINE)));
            end else if (sel < 50) begin
                send_char(any_loaded_code());
            end else if (sel < 60) begin
                send_char(NEWLINE_CODE);
            end else if (sel < 66) begin
                if ($urandom_range(1) == 1) begin
                    code = 8'($urandom_range(255, CODE_LIMIT));
                end else begin
                    code = 8'($urandom_range(FIRST_CODE - 1));
                    if (code == NEWLINE_CODE) begin
                        code = code + 8'd1;
                    end
                end
                send_char(code);
            end else if (sel < 74) begin
                if ($urandom_range(3) != 0) begin
                    send_start(8'($urandom_range(LAST_START_LINE)));
                end else begin
                    send_start(8'($urandom_range(255, LAST_START_LINE + 1)));
                end
            end else if (sel < 88) begin
                send_load(any_loaded_code(), 5'($urandom_range(GLYPH_ROWS - 1)),
                          WORD_W'($urandom));
            end else if (sel < 92) begin
                if ($urandom_range(1) == 1) begin
                    send_load(any_loaded_code(), 5'($urandom_range(31, GLYPH_ROWS)),
                              WORD_W'($urandom));
                end else if ($urandom_range(1) == 1) begin
                    send_load(8'($urandom_range(FIRST_CODE - 1)),
                              5'($urandom_range(31)), WORD_W'($urandom));
                end else begin
                    send_load(8'($urandom_range(255, CODE_LIMIT)),
                              5'($urandom_range(31)), WORD_W'($urandom));
                end
            end else if (sel < 95) begin
                it = random_item();
                it.opcode = OP_UNUSED;
                send_item(it);
            end else if (sel < 98) begin
                code = 8'($urandom_range(CODE_LIMIT - 1, FIRST_CODE));
                if (!glyph_loaded[code - FIRST_CODE]) begin
                    load_glyph(code, 1'b0, '0);
                end else begin
                    send_char(code);
                end
            end else begin
                send_start(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic test_random_phases();
        set_screen($urandom_range(200, 1), $urandom_range(300, 1),
                   COLOR_W'($urandom), COLOR_W'($urandom));
        random_traffic(35);
        idle_pct = 0;
        set_screen(SCREEN_WIDTH_RST, SCREEN_HEIGHT_RST, COLOR_W'($urandom), COLOR_W'($urandom));
        random_traffic(35);
        idle_pct = 36;
        set_screen($urandom_range(2047, 1), $urandom_range(2047, 1),
                   COLOR_W'($urandom), COLOR_W'($urandom));
        random_traffic(35);
        set_screen($urandom_range(4 * CELL_WIDTH, 1), $urandom_range(4 * CELL_HEIGHT, 1),
                   COLOR_W'($urandom), COLOR_W'($urandom));
        random_traffic(35);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        cur_x = 0;
        cur_y = 0;
        text_stopped = 1'b0;
        scr_width = SCREEN_WIDTH_RST;
        scr_height = SCREEN_HEIGHT_RST;
        fg_color = '1;
        bg_color = '0;
        settings_used = 1;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_font_setup();
        test_special_codes();
        test_wrap_and_bottom();
        test_screen_extremes();
        test_output_hold();
        test_random_phases();
        settle();

        $display("Sent %0d input beats under %0d screen settings and checked %0d glyph rows.",
                 beats_sent, settings_used, rows_checked);
        $display("Covered font loads, control and high bytes, wrap, bottom halt and a long hold.");
        if (failures == 0) begin
            $display("bitmap_text_row_renderer_test: PASS");
        end else begin
            $display("bitmap_text_row_renderer_test: FAIL");
        end
        $finish;
    end

endmodule
